[rtl/wncl_pkg.sv]
// Shared constants, opcodes and widths for the weighted nearest centroid labeller.
package wncl_pkg;

  localparam int MaxComp   = 16;
  localparam int MaxDims   = 16;
  localparam int CoordW    = 16;
  localparam int CompW     = $clog2(MaxComp);
  localparam int DimW      = $clog2(MaxDims);
  localparam int AddrW     = CompW + DimW;
  localparam int CntW      = $clog2(MaxDims + 1);
  localparam int LogWW     = 32;
  localparam int AccW      = 36;
  localparam int DiffW     = CoordW + 1;
  localparam int SqW       = 2 * DiffW;
  localparam int Score2W   = AccW + 2;
  localparam int ScoreW    = 37;
  localparam int CfgDataW  = 5;
  localparam int CfgIdxW   = 2;
  localparam int OpW       = 2;

  localparam int InPackW   = CompW + DimW + CoordW + LogWW;
  localparam int InDataW   = ((InPackW + 7) / 8) * 8;
  localparam int OutPackW  = CompW + ScoreW;
  localparam int OutDataW  = ((OutPackW + 7) / 8) * 8;

  localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};

  localparam logic [OpW-1:0] OP_WRITE_MEAN = 2'd0;
  localparam logic [OpW-1:0] OP_WRITE_LOGW = 2'd1;
  localparam logic [OpW-1:0] OP_CLASSIFY   = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_NUM_COMPONENTS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_NUM_DIMS       = 2'd1;

  function automatic logic [CfgDataW-1:0] clamp_cfg(input logic [CfgDataW-1:0] v,
                                                     input logic [CfgDataW-1:0] hi);
    logic [CfgDataW-1:0] r;
    if (v == '0) begin
      r = CfgDataW'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[rtl/wncl_ram.sv]
// Generic single write port RAM with one registered read port.
module wncl_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/weighted_nearest_centroid_label_top.sv]
// Top level of the weighted nearest centroid labeller with its sequencer and shared datapath.
// Write beats, unused beats and classify beats past num_dims are taken directly in the idle state.
// A classify beat inside num_dims makes one mean read per component from the
// mean RAM, through a three stage square and accumulate unit shared by all components.
// A last beat with a mean loaded then compares num_components scores and waits on a held label.
// Reset clears the accumulators, counter, loaded flag and registers; stores stay undefined.
module weighted_nearest_centroid_label_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // Fields from bit 0: component, dim, value, log_weight.
  input  logic [wncl_pkg::InDataW-1:0]  s_axis_tdata,
  // Fields from bit 0: op.
  input  logic [wncl_pkg::OpW-1:0]      s_axis_tuser,
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // Fields from bit 0: label, best_score, zero fill.
  output logic [wncl_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [wncl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [wncl_pkg::CfgDataW-1:0] cfg_data_i
);

  import wncl_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_CMP
  } state_e;

  state_e                state_q;
  logic [CfgDataW-1:0]   num_comp_q;
  logic [CfgDataW-1:0]   num_dims_q;
  logic [CntW-1:0]       coord_cnt_q;
  logic                  loaded_q;
  logic [CoordW-1:0]     sample_q;
  logic                  last_q;
  logic [DimW-1:0]       acc_dim_q;
  logic [CompW:0]        rd_idx_q;
  logic                  s1_v_q;
  logic [CompW-1:0]      s1_idx_q;
  logic                  s2_v_q;
  logic [CompW-1:0]      s2_idx_q;
  logic [SqW-1:0]        sq_q;
  logic [AccW-1:0]       acc_q [MaxComp];
  logic [LogWW-1:0]      lw_q [MaxComp];
  logic [CompW-1:0]      cmp_idx_q;
  logic [CompW-1:0]      best_idx_q;
  logic [Score2W-1:0]    best_q;
  logic                  m_valid_q;
  logic [OutDataW-1:0]   m_data_q;

  logic [CompW-1:0]      in_comp;
  logic [DimW-1:0]       in_dim;
  logic [CoordW-1:0]     in_value;
  logic [LogWW-1:0]      in_logw;
  logic                  in_fire;
  logic [CfgDataW-1:0]   nc;
  logic [CfgDataW-1:0]   nd;
  logic [AddrW-1:0]      ram_raddr;
  logic [CoordW-1:0]     ram_rdata;
  logic                  mean_we;
  logic signed [DiffW-1:0] diff;
  logic signed [SqW-1:0] sq_full;
  logic [AccW:0]         acc_sum;
  logic [AccW-1:0]       acc_next;
  logic [Score2W-1:0]    lw2;
  logic signed [Score2W-1:0] score2;
  logic                  take_new;
  logic [CompW-1:0]      win_idx;
  logic [Score2W-1:0]    win_score;
  logic                  cmp_last;
  logic                  out_free;
  logic                  out_load;

  assign in_comp  = s_axis_tdata[CompW-1:0];
  assign in_dim   = s_axis_tdata[CompW+DimW-1:CompW];
  assign in_value = s_axis_tdata[CompW+DimW+CoordW-1:CompW+DimW];
  assign in_logw  = s_axis_tdata[InPackW-1:CompW+DimW+CoordW];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign mean_we       = in_fire && (s_axis_tuser == OP_WRITE_MEAN);

  assign nc = clamp_cfg(num_comp_q, CfgDataW'(MaxComp));
  assign nd = clamp_cfg(num_dims_q, CfgDataW'(MaxDims));

  assign ram_raddr = {rd_idx_q[CompW-1:0], acc_dim_q};

  wncl_ram #(
    .Width(CoordW),
    .Depth(MaxComp * MaxDims)
  ) u_mean_ram (
    .clk_i   (clk_i),
    .we_i    (mean_we),
    .waddr_i ({in_comp, in_dim}),
    .wdata_i (in_value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign diff     = $signed({sample_q[CoordW-1], sample_q})
                  - $signed({ram_rdata[CoordW-1], ram_rdata});
  assign sq_full  = diff * diff;
  assign acc_sum  = {1'b0, acc_q[s2_idx_q]} + {{(AccW + 1 - SqW){1'b0}}, sq_q};
  assign acc_next = acc_sum[AccW] ? AccMax : acc_sum[AccW-1:0];

  assign lw2      = {{(Score2W - LogWW - 1){lw_q[cmp_idx_q][LogWW-1]}}, lw_q[cmp_idx_q], 1'b0};
  assign score2   = $signed(lw2) - $signed({2'b00, acc_q[cmp_idx_q]});
  assign take_new = (cmp_idx_q == '0) || (score2 > $signed(best_q));
  assign win_idx  = take_new ? cmp_idx_q : best_idx_q;
  assign win_score = take_new ? score2 : best_q;
  assign cmp_last = ({1'b0, cmp_idx_q} == CfgDataW'(nc - CfgDataW'(1)));
  assign out_free = !m_valid_q || m_axis_tready;
  assign out_load = (state_q == ST_CMP) && cmp_last && out_free;

  always_ff @(posedge clk_i) begin
    if (in_fire && (s_axis_tuser == OP_WRITE_LOGW)) begin
      lw_q[in_comp] <= in_logw;
    end
    if (in_fire) begin
      sample_q <= in_value;
    end
    sq_q <= sq_full[SqW-1:0];
    if (state_q == ST_CMP) begin
      best_q     <= win_score;
      best_idx_q <= win_idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      num_comp_q  <= CfgDataW'(1);
      num_dims_q  <= CfgDataW'(MaxDims);
      coord_cnt_q <= '0;
      loaded_q    <= 1'b0;
      last_q      <= 1'b0;
      acc_dim_q   <= '0;
      rd_idx_q    <= '0;
      s1_v_q      <= 1'b0;
      s1_idx_q    <= '0;
      s2_v_q      <= 1'b0;
      s2_idx_q    <= '0;
      cmp_idx_q   <= '0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
      for (int i = 0; i < MaxComp; i++) begin
        acc_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_NUM_COMPONENTS) begin
          num_comp_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_NUM_DIMS) begin
          num_dims_q <= cfg_data_i;
        end
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      s1_v_q   <= (state_q == ST_ACC) && (rd_idx_q < (CompW + 1)'(MaxComp));
      s2_v_q   <= s1_v_q;
      s2_idx_q <= s1_idx_q;
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire && (s_axis_tuser == OP_WRITE_MEAN)) begin
            loaded_q <= 1'b1;
          end
          if (in_fire && (s_axis_tuser == OP_CLASSIFY)) begin
            last_q    <= s_axis_tlast;
            acc_dim_q <= coord_cnt_q[DimW-1:0];
            rd_idx_q  <= '0;
            cmp_idx_q <= '0;
            if (s_axis_tlast) begin
              coord_cnt_q <= '0;
            end else if (coord_cnt_q < CntW'(MaxDims)) begin
              coord_cnt_q <= coord_cnt_q + CntW'(1);
            end
            if (CfgDataW'(coord_cnt_q) < nd) begin
              state_q <= ST_ACC;
            end else if (s_axis_tlast && loaded_q) begin
              state_q <= ST_CMP;
            end else if (s_axis_tlast) begin
              for (int i = 0; i < MaxComp; i++) begin
                acc_q[i] <= '0;
              end
            end
          end
        end
        ST_ACC: begin
          if (rd_idx_q < (CompW + 1)'(MaxComp)) begin
            s1_idx_q <= rd_idx_q[CompW-1:0];
            rd_idx_q <= rd_idx_q + (CompW + 1)'(1);
          end
          if (s2_v_q && (s2_idx_q == CompW'(MaxComp - 1)) && last_q && !loaded_q) begin
            state_q <= ST_IDLE;
            for (int i = 0; i < MaxComp; i++) begin
              acc_q[i] <= '0;
            end
          end else begin
            if (s2_v_q) begin
              acc_q[s2_idx_q] <= acc_next;
            end
            if (s2_v_q && (s2_idx_q == CompW'(MaxComp - 1))) begin
              state_q <= last_q ? ST_CMP : ST_IDLE;
            end
          end
        end
        ST_CMP: begin
          if (!cmp_last) begin
            cmp_idx_q <= cmp_idx_q + CompW'(1);
          end else if (out_free) begin
            m_data_q  <= OutDataW'({win_score[Score2W-1:1], win_idx});
            state_q   <= ST_IDLE;
            for (int i = 0; i < MaxComp; i++) begin
              acc_q[i] <= '0;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_acc_only_in_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> (state_q == ST_ACC))
    else $error("Accumulate stage active outside accumulation.");

  a_cmp_needs_model: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> loaded_q)
    else $error("Compare entered with no mean loaded.");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coord_cnt_q <= CntW'(MaxDims))
    else $error("Coordinate counter beyond the dimension count.");

  a_last_clears_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (s_axis_tuser == OP_CLASSIFY) && s_axis_tlast) |=> (coord_cnt_q == '0))
    else $error("Coordinate counter not cleared after a last beat.");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready) |=> (m_valid_q && $stable(m_data_q)))
    else $error("Pending result changed before it was taken.");

endmodule

[verif/tb.sv]
// Self-checking testbench for the weighted nearest centroid labeller top level.
`timescale 1ns / 1ps

module tb;
  import wncl_pkg::*;

  localparam logic [OpW-1:0]     OP_UNUSED  = 2'd3;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd2;
  localparam longint AccLimit = (longint'(1) << AccW) - 1;

  typedef struct packed {
    logic [CompW-1:0]  label;
    logic [ScoreW-1:0] score;
  } label_beat_t;

  class label_predictor;
    logic signed [CoordW-1:0] means [MaxComp*MaxDims];
    logic signed [LogWW-1:0]  log_weights [MaxComp];
    longint                   dist_acc [MaxComp];
    int                       coord_cnt;
    bit                       loaded;
    logic [CfgDataW-1:0]      comp_reg;
    logic [CfgDataW-1:0]      dims_reg;
    label_beat_t              pending_labels [$];
    int                       mismatches;
    int                       labels_seen;

    function new();
      comp_reg    = 5'd1;
      dims_reg    = 5'd16;
      coord_cnt   = 0;
      loaded      = 1'b0;
      mismatches  = 0;
      labels_seen = 0;
      foreach (dist_acc[c]) dist_acc[c] = 0;
    endfunction

    function int clamp_count(logic [CfgDataW-1:0] v, int hi);
      if (v == '0) return 1;
      return (int'(v) > hi) ? hi : int'(v);
    endfunction

    function int dims_used();
      return clamp_count(dims_reg, MaxDims);
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == CFG_NUM_COMPONENTS) comp_reg = val;
      else if (idx == CFG_NUM_DIMS) dims_reg = val;
    endfunction

    function void note_beat(logic [OpW-1:0] op, logic [CompW-1:0] comp,
                            logic [DimW-1:0] dim, logic signed [CoordW-1:0] value,
                            logic signed [LogWW-1:0] lw, logic last);
      longint      diff;
      longint      sum;
      longint      top2;
      longint      cand;
      int          top;
      int          nc;
      label_beat_t exp_beat;
      if (op == OP_WRITE_MEAN) begin
        means[{comp, dim}] = value;
        loaded = 1'b1;
        return;
      end
      if (op == OP_WRITE_LOGW) begin
        log_weights[comp] = lw;
        return;
      end
      if (op != OP_CLASSIFY) return;
      if (coord_cnt < dims_used()) begin
        for (int c = 0; c < MaxComp; c++) begin
          diff = longint'(value) - longint'(means[c*MaxDims + coord_cnt]);
          if (diff < 0) diff = -diff;
          sum = dist_acc[c] + ((diff >= 64'sd262144) ? AccLimit : diff * diff);
          dist_acc[c] = (sum > AccLimit) ? AccLimit : sum;
        end
      end
      if (coord_cnt < MaxDims) coord_cnt++;
      if (!last) return;
      if (loaded) begin
        nc   = clamp_count(comp_reg, MaxComp);
        top  = 0;
        top2 = 2 * longint'(log_weights[0]) - dist_acc[0];
        for (int c = 1; c < nc; c++) begin
          cand = 2 * longint'(log_weights[c]) - dist_acc[c];
          if (cand > top2) begin
            top2 = cand;
            top  = c;
          end
        end
        exp_beat.label = CompW'(top);
        exp_beat.score = ScoreW'(top2 >>> 1);
        pending_labels.push_back(exp_beat);
      end
      foreach (dist_acc[c]) dist_acc[c] = 0;
      coord_cnt = 0;
    endfunction

    function void check_label(logic [CompW-1:0] label, logic [ScoreW-1:0] score);
      label_beat_t exp_beat;
      labels_seen++;
      if (pending_labels.size() == 0) begin
        $error("label beat with no expected result: label %0d", label);
        mismatches++;
        return;
      end
      exp_beat = pending_labels.pop_front();
      if (label !== exp_beat.label) begin
        $error("label: expected %0d, actual %0d", exp_beat.label, label);
        mismatches++;
      end
      if (score !== exp_beat.score) begin
        $error("best_score: expected %0d, actual %0d",
               $signed(exp_beat.score), $signed(score));
        mismatches++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_n = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [OpW-1:0]      s_tuser = '0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  label_predictor sb = new();
  bit             quiet = 1'b0;
  bit             hold_req = 1'b0;
  int             items_sent = 0;

  weighted_nearest_centroid_label_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [CoordW-1:0] rand_coord();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return r[CoordW-1:0];
    endcase
  endfunction

  function automatic logic [LogWW-1:0] rand_logw();
    logic [31:0] r;
    r = $urandom;
    if ($urandom_range(7) == 0) return r;
    return r[31] ? r : -r;
  endfunction

  task automatic send_item(input logic [OpW-1:0] op, input logic [CompW-1:0] comp,
                           input logic [DimW-1:0] dim, input logic [CoordW-1:0] value,
                           input logic [LogWW-1:0] lw, input logic last);
    if (!quiet && $urandom_range(3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {lw, value, dim, comp};
    s_tuser  <= op;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
    sb.note_beat(op, comp, dim, value, lw, last);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic send_coord(input logic [CoordW-1:0] value, input logic last);
    send_item(OP_CLASSIFY, CompW'($urandom), DimW'($urandom), value, $urandom, last);
  endtask

  task automatic drain_block();
    s_tvalid <= 1'b0;
    while (sb.pending_labels.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  initial begin
    int  stall_left;
    bit  held;
    stall_left = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_tvalid && m_tready)
        sb.check_label(m_tdata[CompW-1:0], m_tdata[CompW +: ScoreW]);
      if (!held && hold_req && s_tvalid && !s_tready) begin
        // Long receiver hold-off so the block backs up and stalls its input.
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!quiet && $urandom_range(3) == 0) begin
        stall_left = $urandom_range(1, 3) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int                  phase_end;
    int                  phase;
    int                  r;
    int                  k;
    int                  len;
    int                  nd_eff;
    logic [CfgDataW-1:0] nc_val;
    logic [CfgDataW-1:0] nd_val;
    repeat (9) @(posedge clk_i);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Before any mean is loaded an unused op and a last coordinate give no label.
    send_item(OP_UNUSED, CompW'($urandom), DimW'($urandom), CoordW'($urandom), $urandom, 1'b1);
    send_item(OP_CLASSIFY, 4'd0, 4'd0, 16'h7fff, 32'd0, 1'b1);
    for (int c = 0; c < MaxComp; c++)
      for (int d = 0; d < MaxDims; d++)
        send_item(OP_WRITE_MEAN, CompW'(c), DimW'(d), rand_coord(), $urandom, 1'($urandom));
    for (int c = 0; c < MaxComp; c++)
      send_item(OP_WRITE_LOGW, CompW'(c), DimW'($urandom), CoordW'($urandom), rand_logw(),
                1'($urandom));

    drain_block();
    write_cfg(CFG_NUM_COMPONENTS, 5'd16);
    write_cfg(CFG_NUM_DIMS, 5'd2);
    write_cfg(CFG_UNUSED, 5'd31);
    send_coord(16'h7fff, 1'b0);
    send_coord(16'h8000, 1'b1);
    send_coord(16'h8000, 1'b0);
    send_coord(16'h7fff, 1'b0);
    send_coord(16'h7fff, 1'b0);
    send_coord(16'h8000, 1'b1);
    send_coord(16'h0000, 1'b1);

    drain_block();
    write_cfg(CFG_NUM_DIMS, 5'd1);
    // Components zero and one score the same; the lower index must win.
    send_item(OP_WRITE_MEAN, 4'd0, 4'd0, 16'd100, $urandom, 1'b0);
    send_item(OP_WRITE_MEAN, 4'd1, 4'd0, 16'd100, $urandom, 1'b1);
    send_item(OP_WRITE_LOGW, 4'd0, DimW'($urandom), CoordW'($urandom), 32'd0, 1'b0);
    send_item(OP_WRITE_LOGW, 4'd1, DimW'($urandom), CoordW'($urandom), 32'd0, 1'b0);
    send_coord(16'd100, 1'b1);
    send_item(OP_WRITE_LOGW, 4'd5, DimW'($urandom), CoordW'($urandom), 32'h7fff_ffff, 1'b0);
    send_coord(16'h8000, 1'b1);
    send_item(OP_WRITE_LOGW, 4'd5, DimW'($urandom), CoordW'($urandom), 32'h8000_0000, 1'b0);
    send_coord(16'h7fff, 1'b1);

    drain_block();
    write_cfg(CFG_NUM_COMPONENTS, 5'd1);
    send_coord(rand_coord(), 1'b1);

    phase = 0;
    while (items_sent < 650) begin
      case (phase % 8)
        0: begin nc_val = 5'd16; nd_val = 5'd16; end
        1: begin nc_val = 5'd16; nd_val = 5'd3; end
        2: begin nc_val = 5'd0; nd_val = 5'd0; end
        3: begin nc_val = 5'd31; nd_val = 5'd31; end
        4: begin nc_val = 5'd1; nd_val = 5'd16; end
        5: begin
          nc_val = CfgDataW'($urandom_range(1, 16));
          nd_val = CfgDataW'($urandom_range(1, 4));
        end
        6: begin nc_val = 5'd8; nd_val = 5'd1; end
        default: begin
          nc_val = CfgDataW'($urandom_range(0, 31));
          nd_val = CfgDataW'($urandom_range(0, 31));
        end
      endcase
      drain_block();
      write_cfg(CFG_NUM_COMPONENTS, nc_val);
      write_cfg(CFG_NUM_DIMS, nd_val);
      hold_req  = (phase % 8 == 2);
      phase_end = items_sent + 45;
      while (items_sent < phase_end) begin
        quiet = (items_sent >= 590);
        r = $urandom_range(99);
        if (r < 12) begin
          send_item(OP_WRITE_MEAN, CompW'($urandom), DimW'($urandom), rand_coord(),
                    $urandom, 1'($urandom));
        end else if (r < 20) begin
          send_item(OP_WRITE_LOGW, CompW'($urandom), DimW'($urandom), CoordW'($urandom),
                    rand_logw(), 1'($urandom));
        end else if (r < 23) begin
          send_item(OP_UNUSED, CompW'($urandom), DimW'($urandom), CoordW'($urandom),
                    $urandom, 1'($urandom));
        end else begin
          nd_eff = sb.dims_used();
          k = $urandom_range(99);
          if (k < 70) len = nd_eff;
          else if (k < 82) len = $urandom_range(1, nd_eff);
          else if (k < 96) len = nd_eff + $urandom_range(1, 3);
          else len = $urandom_range(33, 36);
          for (int i = 0; i < len; i++) send_coord(rand_coord(), i == len - 1);
        end
      end
      phase++;
    end

    s_tvalid <= 1'b0;
    while (sb.pending_labels.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_labels.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[weighted_nearest_centroid_label_top.f]
rtl/wncl_pkg.sv
rtl/wncl_ram.sv
rtl/weighted_nearest_centroid_label_top.sv
verif/tb.sv
